FILE: sv/car_pkg.sv
package car_pkg;

  // Field widths
  localparam int unsigned ID_W    = 48;
  localparam int unsigned ALIAS_W = 12;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned SEQ_W   = 3;
  localparam int unsigned CFG_IDX_W = 1;

  // Input operation codes
  localparam logic [OP_W-1:0] OP_START   = 3'd0;
  localparam logic [OP_W-1:0] OP_REPLY   = 3'd1;
  localparam logic [OP_W-1:0] OP_SENT    = 3'd2;
  localparam logic [OP_W-1:0] OP_TICK    = 3'd3;
  localparam logic [OP_W-1:0] OP_RX      = 3'd4;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_REQ     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ID    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_TICKS = 1'b1;

  localparam logic [TICK_W-1:0]  WAIT_TICKS_RST = 16'd200;
  localparam logic [SEQ_W-1:0]   SEQ_FIRST      = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic               in_use;
    logic [ALIAS_W-1:0] frame_alias;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ALIAS_W-1:0] alias_res;
    logic [SEQ_W-1:0]   frame_seq;
    logic [ALIAS_W-1:0] content;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   node_id;
    logic [TICK_W-1:0] wait_ticks;
    logic              id_wr;
  } cfg_t;

  // Generator seed: XOR folds of the identifier, low 12 bits
  function automatic logic [ALIAS_W-1:0] seed_fold(input logic [ID_W-1:0] id);
    seed_fold = id[41:30] ^ id[29:18] ^ id[17:6] ^ {id[5:0], id[47:42]};
  endfunction

  // Generator step: odd, from identifier folds
  function automatic logic [ALIAS_W-1:0] step_fold(input logic [ID_W-1:0] id);
    logic [ALIAS_W-2:0] x;
    x = id[46:36] ^ id[34:24] ^ id[22:12] ^ id[10:0];
    step_fold = {x, 1'b1};
  endfunction

  // Identifier bits carried by a check frame
  function automatic logic [ALIAS_W-1:0] frame_content(input logic [ID_W-1:0] id,
                                                       input logic [1:0] sel);
    case (sel)
      2'd3:    frame_content = id[47:36];
      2'd2:    frame_content = id[35:24];
      2'd1:    frame_content = id[23:12];
      default: frame_content = id[11:0];
    endcase
  endfunction

endpackage

FILE: sv/car_engine.sv
module car_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  car_pkg::cfg_t     cfg,
  input  logic              item_valid,
  input  car_pkg::in_item_t item,
  output logic              res_valid,
  output car_pkg::out_item_t res
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_CAND  = 2'd1;
  localparam logic [1:0] PH_CHECK = 2'd2;
  localparam logic [1:0] PH_WAIT  = 2'd3;

  logic [1:0]                     phase_r, phase_nxt;
  logic [car_pkg::ALIAS_W-1:0]    seed_r, seed_nxt;
  logic                           seed_ld_r, seed_ld_nxt;
  logic [car_pkg::ALIAS_W-1:0]    pending_r, pending_nxt;
  logic [car_pkg::SEQ_W-1:0]      seq_r, seq_nxt;
  logic                           conflict_r, conflict_nxt;
  logic [car_pkg::TICK_W-1:0]     wait_r, wait_nxt;

  logic [car_pkg::ALIAS_W-1:0]    seed_base, step, seed_one, cand, seed_after;
  logic [car_pkg::TICK_W-1:0]     wait_dec;
  logic                           do_draw, do_check, do_reserve;

  // Candidate draw: skip a zero value with one extra step
  always_comb begin
    seed_base  = seed_ld_r ? seed_r : car_pkg::seed_fold(cfg.node_id);
    step       = car_pkg::step_fold(cfg.node_id);
    seed_one   = seed_base + step;
    cand       = (seed_base == '0) ? seed_one : seed_base;
    seed_after = (seed_base == '0) ? seed_one + step : seed_one;
    wait_dec   = (wait_r == '0) ? '0 : wait_r - 1'b1;
  end

  // Decode the item and pick the action
  always_comb begin
    phase_nxt    = phase_r;
    wait_nxt     = wait_r;
    conflict_nxt = conflict_r;
    do_draw      = 1'b0;
    do_check     = 1'b0;
    do_reserve   = 1'b0;
    if (item_valid) begin
      unique case (item.op)
        car_pkg::OP_START: begin
          do_draw = (phase_r == PH_IDLE);
        end
        car_pkg::OP_REPLY: begin
          if (phase_r == PH_CAND) begin
            if (item.in_use) begin
              do_draw = 1'b1;
            end else begin
              phase_nxt = PH_CHECK;
              do_check  = 1'b1;
            end
          end
        end
        car_pkg::OP_SENT: begin
          if (phase_r == PH_CHECK) begin
            if (conflict_r) begin
              do_draw = 1'b1;
            end else if (seq_r[2]) begin
              do_check = 1'b1;
            end else begin
              phase_nxt = PH_WAIT;
              wait_nxt  = (cfg.wait_ticks == '0) ? car_pkg::TICK_W'(1) : cfg.wait_ticks;
            end
          end
        end
        car_pkg::OP_TICK: begin
          if (phase_r == PH_WAIT) begin
            wait_nxt = wait_dec;
            if (wait_dec == '0) begin
              if (conflict_r) begin
                do_draw = 1'b1;
              end else begin
                phase_nxt  = PH_IDLE;
                do_reserve = 1'b1;
              end
            end
          end
        end
        car_pkg::OP_RX: begin
          if ((phase_r == PH_CHECK || phase_r == PH_WAIT) && !conflict_r &&
              item.frame_alias == pending_r) begin
            conflict_nxt = 1'b1;
            do_draw      = (phase_r == PH_WAIT);
          end
        end
        default: ;
      endcase
    end
  end

  // Apply the action and build the result item
  always_comb begin
    seed_nxt    = seed_r;
    seed_ld_nxt = seed_ld_r;
    pending_nxt = pending_r;
    seq_nxt     = seq_r;
    res_valid   = 1'b0;
    res         = '0;
    if (do_draw) begin
      seed_nxt      = seed_after;
      seed_ld_nxt   = 1'b1;
      pending_nxt   = cand;
      seq_nxt       = car_pkg::SEQ_FIRST;
      res_valid     = 1'b1;
      res.kind      = car_pkg::KIND_REQ;
      res.alias_res = cand;
    end else if (do_check) begin
      seq_nxt       = seq_r - 1'b1;
      res_valid     = 1'b1;
      res.kind      = car_pkg::KIND_CHECK;
      res.alias_res = pending_r;
      res.frame_seq = seq_r;
      res.content   = car_pkg::frame_content(cfg.node_id, seq_r[1:0]);
    end else if (do_reserve) begin
      res_valid     = 1'b1;
      res.kind      = car_pkg::KIND_RESERVE;
      res.alias_res = pending_r;
    end
    // New identifier: reload the generator on the next draw
    if (cfg.id_wr) begin
      seed_ld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      seed_r     <= '0;
      seed_ld_r  <= 1'b0;
      pending_r  <= '0;
      seq_r      <= car_pkg::SEQ_FIRST;
      conflict_r <= 1'b0;
      wait_r     <= '0;
    end else begin
      phase_r    <= do_draw ? PH_CAND : phase_nxt;
      seed_r     <= seed_nxt;
      seed_ld_r  <= seed_ld_nxt;
      pending_r  <= pending_nxt;
      seq_r      <= seq_nxt;
      conflict_r <= do_draw ? 1'b0 : conflict_nxt;
      wait_r     <= wait_nxt;
    end
  end

  // A noted conflict only lives while check frames go out
  a_conflict_in_check: assert property (@(posedge clk) disable iff (!rst_n)
    conflict_r |-> phase_r == PH_CHECK)
    else $error("conflict flag set outside check phase");

  // All four check frames are gone before the wait
  a_wait_seq: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_WAIT |-> seq_r == 3'd3)
    else $error("wait phase entered with check frames left");

  // A drawn candidate is never zero
  a_pending_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_IDLE |-> pending_r != '0)
    else $error("zero alias pending");

  // Check frames carry sequence 7 down to 4
  a_check_seq: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind == car_pkg::KIND_CHECK |-> res.frame_seq[2])
    else $error("check frame sequence out of range");

  // A reserve result returns the engine to idle
  a_reserve_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind == car_pkg::KIND_RESERVE |=> phase_r == PH_IDLE)
    else $error("reserve without return to idle");

endmodule

FILE: sv/can_alias_reservation.sv
// Channel  | Ports                           | Item
// ---------+---------------------------------+-------------------------------------
// input    | in_valid, in_ready, in_data     | op, in_use, frame_alias
// result   | out_valid, out_ready, out_data  | kind, alias_res, frame_seq, content
// config   | cfg_we, cfg_idx, cfg_wdata      | 0 node_id, 1 wait_ticks
//
// One item per cycle unless a held result stalls: an item is held in the input
// register, then the state update and result logic load the output register.
// Reset (rst_n low, synchronous) returns to idle with wait_ticks 200.
// A held result stalls the input register; in_ready drops only while both
// the input register and the output register are full and out_ready is low.
module can_alias_reservation (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  car_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output car_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [car_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [car_pkg::ID_W-1:0]        cfg_wdata
);

  logic                          in_vld_r, in_vld_nxt;
  car_pkg::in_item_t             in_q_r;
  logic                          out_vld_r, out_vld_nxt;
  car_pkg::out_item_t            out_q_r;
  logic [car_pkg::ID_W-1:0]      node_id_r;
  logic [car_pkg::TICK_W-1:0]    wait_ticks_r;
  logic                          step_fire;
  logic                          res_valid;
  car_pkg::out_item_t            res;
  car_pkg::cfg_t                 cfg;

  // Advance the input register when the output slot is free
  assign step_fire = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || step_fire;

  always_comb begin
    in_vld_nxt = in_vld_r && !step_fire;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end
    out_vld_nxt = out_vld_r && !out_ready;
    if (step_fire && res_valid) begin
      out_vld_nxt = 1'b1;
    end
    cfg.node_id    = node_id_r;
    cfg.wait_ticks = wait_ticks_r;
    cfg.id_wr      = cfg_we && (cfg_idx == car_pkg::REG_NODE_ID);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      node_id_r    <= '0;
      wait_ticks_r <= car_pkg::WAIT_TICKS_RST;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          car_pkg::REG_NODE_ID:    node_id_r    <= cfg_wdata;
          car_pkg::REG_WAIT_TICKS: wait_ticks_r <= cfg_wdata[car_pkg::TICK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Hold payloads; no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q_r <= in_data;
    end
    if (step_fire && res_valid) begin
      out_q_r <= res;
    end
  end

  car_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (step_fire),
    .item       (in_q_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_q_r;

endmodule

FILE: tb/sv/tb_can_alias_reservation.sv
`timescale 1ns / 1ps

module tb_can_alias_reservation;
  import car_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam logic [OP_W-1:0] OP_UNKNOWN_FIRST = OP_RX + 3'd1;
  localparam logic [OP_W-1:0] OP_UNKNOWN_LAST  = '1;
  localparam logic [SEQ_W-1:0] SEQ_LAST = 3'd4;

  typedef enum logic [1:0] {RS_IDLE, RS_CAND, RS_CHECK, RS_WAIT} resv_phase_t;

  // Alias reservation predictor and queue of expected frames
  class alias_scoreboard;
    logic [ID_W-1:0]    node_id;
    logic [TICK_W-1:0]  wait_ticks;
    resv_phase_t        phase;
    logic [ALIAS_W-1:0] gen;
    bit                 gen_loaded;
    logic [ALIAS_W-1:0] pending;
    logic [SEQ_W-1:0]   seq;
    bit                 conflict;
    logic [TICK_W-1:0]  ticks_left;
    out_item_t          expected_frames[$];
    int                 errors;

    function new();
      node_id    = '0;
      wait_ticks = WAIT_TICKS_RST;
      phase      = RS_IDLE;
      gen        = '0;
      gen_loaded = 0;
      pending    = '0;
      seq        = SEQ_FIRST;
      conflict   = 0;
      ticks_left = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ID_W-1:0] val);
      if (idx == REG_NODE_ID) begin
        node_id    = val;
        gen_loaded = 0;
      end else begin
        wait_ticks = val[TICK_W-1:0];
      end
    endfunction

    function void push(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] fseq,
                       logic [ALIAS_W-1:0] bits);
      out_item_t e;
      e.kind      = kind;
      e.alias_res = pending;
      e.frame_seq = fseq;
      e.content   = bits;
      expected_frames.push_back(e);
    endfunction

    // Seed the generator from shifted copies of the identifier
    function void load_gen();
      logic [63:0] id;
      logic [31:0] fold, hi, lo;
      id   = 64'(node_id);
      fold = 32'(id >> 30) ^ 32'(id >> 18) ^ 32'(id >> 6);
      hi   = 32'((id >> 42) & 64'hFFFF);
      lo   = 32'((id << 6) & 64'hFFFF);
      fold = fold ^ (hi | lo);
      gen  = fold[ALIAS_W-1:0];
      gen_loaded = 1;
    endfunction

    // Advance by an odd stride so every 12-bit value comes up once per lap
    function void step_gen();
      logic [63:0] id, x;
      logic [15:0] stride;
      id     = 64'(node_id);
      x      = (id >> 36) ^ (id >> 24) ^ (id >> 12) ^ id;
      stride = {x[14:0], 1'b1};
      gen    = gen + stride[ALIAS_W-1:0];
    endfunction

    // Draw a nonzero candidate and ask whether it is taken
    function void draw();
      logic [ALIAS_W-1:0] cand;
      if (!gen_loaded) load_gen();
      cand = gen;
      step_gen();
      if (cand == '0) begin
        cand = gen;
        step_gen();
      end
      pending  = cand;
      seq      = SEQ_FIRST;
      conflict = 0;
      phase    = RS_CAND;
      push(KIND_REQ, '0, '0);
    endfunction

    function void send_check();
      logic [SEQ_W-1:0] s;
      logic [ID_W-1:0]  sh;
      s   = seq;
      sh  = node_id >> (12 * s[1:0]);
      seq = s - 1'b1;
      push(KIND_CHECK, s, sh[ALIAS_W-1:0]);
    endfunction

    // Advance the predictor by one accepted item
    function void note_item(in_item_t it);
      case (it.op)
        OP_START: if (phase == RS_IDLE) draw();
        OP_REPLY: if (phase == RS_CAND) begin
          if (it.in_use) begin
            draw();
          end else begin
            phase = RS_CHECK;
            send_check();
          end
        end
        OP_SENT: if (phase == RS_CHECK) begin
          if (conflict) begin
            draw();
          end else if (seq >= SEQ_LAST) begin
            send_check();
          end else begin
            phase      = RS_WAIT;
            ticks_left = (wait_ticks != '0) ? wait_ticks : TICK_W'(1);
          end
        end
        OP_TICK: if (phase == RS_WAIT) begin
          if (ticks_left != '0) ticks_left--;
          if (ticks_left == '0) begin
            if (conflict) begin
              draw();
            end else begin
              phase = RS_IDLE;
              push(KIND_RESERVE, '0, '0);
            end
          end
        end
        OP_RX: if ((phase == RS_CHECK || phase == RS_WAIT) && !conflict &&
                   it.frame_alias == pending) begin
          conflict = 1;
          if (phase == RS_WAIT) draw();
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result with the oldest expected frame
    function void check_frame(out_item_t got);
      out_item_t want;
      if (expected_frames.size() == 0) begin
        $error("unexpected result: kind %0d alias %0h", got.kind, got.alias_res);
        errors++;
        return;
      end
      want = expected_frames.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.alias_res !== want.alias_res) begin
        $error("alias_res: expected %0h, got %0h", want.alias_res, got.alias_res);
        errors++;
      end
      if (got.frame_seq !== want.frame_seq) begin
        $error("frame_seq: expected %0d, got %0d", want.frame_seq, got.frame_seq);
        errors++;
      end
      if (got.content !== want.content) begin
        $error("content: expected %0h, got %0h", want.content, got.content);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_frames.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [ID_W-1:0]      cfg_wdata;

  int          idle_pct;
  int          stall_pct;
  int unsigned quiet_cycles;
  alias_scoreboard sb;

  can_alias_reservation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Check results, then note accepted items
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_frame(out_data);
      if (in_valid && in_ready) sb.note_item(in_data);
    end
  end

  // Give up when no item moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[can_alias_reservation] ERROR");
      $finish;
    end
  end

  function automatic in_item_t mk_item(logic [OP_W-1:0] op, logic in_use,
                                       logic [ALIAS_W-1:0] fa);
    in_item_t it;
    it.op          = op;
    it.in_use      = in_use;
    it.frame_alias = fa;
    return it;
  endfunction

  function automatic logic [ID_W-1:0] random_id();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ID_W-1:0];
  endfunction

  // Pick the item that moves the reservation on, with some noise and conflicts
  function automatic in_item_t next_item(int noise_pct, int conflict_pct);
    in_item_t it;
    int roll;
    it = mk_item(OP_START, $urandom_range(1), $urandom_range(4095));
    roll = $urandom_range(99);
    if (roll < noise_pct) begin
      it.op = $urandom_range(7);
      return it;
    end
    roll = $urandom_range(99);
    case (sb.phase)
      RS_IDLE: it.op = OP_START;
      RS_CAND: begin
        it.op     = OP_REPLY;
        it.in_use = (roll < 25);
      end
      default: begin
        if (roll < conflict_pct) begin
          it.op          = OP_RX;
          it.frame_alias = sb.pending;
        end else if (roll < 2 * conflict_pct) begin
          it.op = OP_RX;
        end else begin
          it.op = (sb.phase == RS_CHECK) ? OP_SENT : OP_TICK;
        end
      end
    endcase
    return it;
  endfunction

  // Offer one item after a random gap; return at the falling edge after acceptance
  task automatic drive(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ID_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Finish the current reservation, then drain all results and let the pipe empty
  task automatic settle(input int conflict_pct);
    while (sb.phase != RS_IDLE) drive(next_item(0, conflict_pct));
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_random(input int count, input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (count) drive(next_item(12, 8));
    settle(4);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    sb = new();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: identifier zero gives a zero first candidate, which is skipped
    cfg_write(REG_WAIT_TICKS, 2);
    cfg_write(REG_NODE_ID, '0);

    // Drop everything but a start while idle
    drive(mk_item(OP_TICK, 1'b0, '1));
    drive(mk_item(OP_REPLY, 1'b1, '0));
    drive(mk_item(OP_SENT, 1'b0, '0));
    drive(mk_item(OP_RX, 1'b0, '0));
    for (int code = OP_UNKNOWN_FIRST; code <= OP_UNKNOWN_LAST; code++)
      drive(mk_item(code, 1'b1, '1));

    // Full reservation with a taken candidate and ignored items on the way
    drive(mk_item(OP_START, 1'b0, '0));
    drive(mk_item(OP_START, 1'b1, '1));
    drive(mk_item(OP_RX, 1'b0, sb.pending));
    drive(mk_item(OP_SENT, 1'b0, '0));
    drive(mk_item(OP_REPLY, 1'b1, '0));
    drive(mk_item(OP_REPLY, 1'b0, '0));
    drive(mk_item(OP_RX, 1'b0, ~sb.pending));
    repeat (4) drive(mk_item(OP_SENT, 1'b0, '0));
    repeat (2) drive(mk_item(OP_TICK, 1'b0, '0));

    // Conflict while sending check frames, repeated, then on the next completion
    drive(mk_item(OP_START, 1'b0, '0));
    drive(mk_item(OP_REPLY, 1'b0, '0));
    repeat (2) drive(mk_item(OP_RX, 1'b0, sb.pending));
    drive(mk_item(OP_SENT, 1'b0, '0));

    // Conflict while waiting restarts at once
    drive(mk_item(OP_REPLY, 1'b0, '0));
    repeat (4) drive(mk_item(OP_SENT, 1'b0, '0));
    drive(mk_item(OP_RX, 1'b0, sb.pending));
    settle(4);

    // Random phases under different settings and idling
    cfg_write(REG_NODE_ID, '1);
    cfg_write(REG_WAIT_TICKS, 0);
    run_random(250, 0, 0);

    cfg_write(REG_NODE_ID, random_id());
    cfg_write(REG_WAIT_TICKS, 1);
    run_random(250, 77, 0);

    cfg_write(REG_NODE_ID, random_id());
    cfg_write(REG_WAIT_TICKS, $urandom_range(6, 1));
    run_random(250, 0, 77);

    cfg_write(REG_NODE_ID, random_id());
    cfg_write(REG_WAIT_TICKS, 3);
    run_random(250, 7, 7);

    // One reservation through a longer wait
    cfg_write(REG_WAIT_TICKS, 40);
    cfg_write(REG_NODE_ID, random_id());
    idle_pct  = 0;
    stall_pct = 0;
    do drive(next_item(0, 0)); while (sb.phase != RS_IDLE);
    settle(0);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("[can_alias_reservation] OK");
    end else begin
      $display("[can_alias_reservation] ERROR");
    end
    $finish;
  end

endmodule
